FILE: src/sat_pkg.sv
// Shared types and constants of the slot aggregation tracker.
`default_nettype none
package sat_pkg;

    // Slot and port geometry
    localparam int SLOTS  = 256;
    localparam int PORTS  = 32;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int PORT_W = 5;
    localparam int CNT_W  = 6;

    // Configuration register indexes
    localparam logic [2:0] REG_WORKER_COUNT   = 3'd0;
    localparam logic [2:0] REG_UPDATE_COUNT   = 3'd1;
    localparam logic [2:0] REG_IS_TOP_LEVEL   = 3'd2;
    localparam logic [2:0] REG_DOWN_PORT_MASK = 3'd3;
    localparam logic [2:0] REG_JOB_FINISHED   = 3'd4;

    // Packet commands
    localparam logic CMD_UP   = 1'b0;
    localparam logic CMD_DOWN = 1'b1;

    typedef enum logic [2:0] {
        ACT_DROP  = 3'd0,
        ACT_REPLY = 3'd1,
        ACT_UP    = 3'd2,
        ACT_MCAST = 3'd3,
        ACT_ERROR = 3'd4
    } sat_action_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC1,
        ST_CALC2
    } sat_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;   // write a zero row at the sweep counter
        logic load;    // take a word, read its slot row
        logic calc;    // first remainder step
        logic commit;  // second remainder, write back, load result
    } sat_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic out_busy;
    } sat_stat_t;

endpackage
`default_nettype wire

FILE: src/sat_ctrl.sv
// Controller state machine of the slot aggregation tracker.
`default_nettype none
module sat_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire sat_pkg::sat_stat_t stat,
    output sat_pkg::sat_cmd_t     cmd,
    output logic                  ready
);

    sat_pkg::sat_state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sat_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sat_pkg::ST_CLEAR: begin
                if (stat.clear_done) state_next = sat_pkg::ST_IDLE;
            end
            sat_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = sat_pkg::ST_CALC1;
            end
            sat_pkg::ST_CALC1: begin
                state_next = sat_pkg::ST_CALC2;
            end
            sat_pkg::ST_CALC2: begin
                if (!stat.out_busy) state_next = sat_pkg::ST_IDLE;
            end
            default: state_next = sat_pkg::ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        cmd   = '0;
        ready = 1'b0;
        unique case (state_reg)
            sat_pkg::ST_CLEAR: cmd.clear = 1'b1;
            sat_pkg::ST_IDLE: begin
                ready    = 1'b1;
                cmd.load = s_tvalid;
            end
            sat_pkg::ST_CALC1: cmd.calc = 1'b1;
            sat_pkg::ST_CALC2: cmd.commit = !stat.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: src/sat_datapath.sv
// Datapath of the slot aggregation tracker: slot memories, config, result register.
`default_nettype none
module sat_datapath (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire sat_pkg::sat_cmd_t      cmd,
    output sat_pkg::sat_stat_t          stat,
    input  wire logic [15:0]            s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [23:0]                 m_tdata,
    input  wire logic                   cfg_we,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [31:0]            cfg_wdata
);

    localparam int SW = sat_pkg::SLOT_W;
    localparam int PN = sat_pkg::PORTS;
    localparam int CW = sat_pkg::CNT_W;

    // Remainder of a 7-bit value by a nonzero 6-bit divisor, one bit a step
    function automatic logic [5:0] mod_small(input logic [6:0] a, input logic [5:0] d);
        logic [6:0] r;
        r = '0;
        for (int i = 6; i >= 0; i--) begin
            r = {r[5:0], a[i]};
            if (r >= {1'b0, d}) r = r - {1'b0, d};
        end
        return r[5:0];
    endfunction

    // Configuration registers
    logic [CW-1:0] worker_count_reg, update_count_reg;
    logic          is_top_level_reg, job_finished_reg;
    logic [31:0]   down_port_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            worker_count_reg   <= CW'(1);
            update_count_reg   <= CW'(1);
            is_top_level_reg   <= 1'b0;
            down_port_mask_reg <= '0;
            job_finished_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sat_pkg::REG_WORKER_COUNT:   worker_count_reg   <= cfg_wdata[CW-1:0];
                sat_pkg::REG_UPDATE_COUNT:   update_count_reg   <= cfg_wdata[CW-1:0];
                sat_pkg::REG_IS_TOP_LEVEL:   is_top_level_reg   <= cfg_wdata[0];
                sat_pkg::REG_DOWN_PORT_MASK: down_port_mask_reg <= cfg_wdata;
                sat_pkg::REG_JOB_FINISHED:   job_finished_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Zero register value acts as one
    logic [CW-1:0] w, u;
    assign w = (worker_count_reg == '0) ? CW'(1) : worker_count_reg;
    assign u = (update_count_reg == '0) ? CW'(1) : update_count_reg;

    // Clearing sweep counter, one row per cycle
    logic [SW-1:0] clr_cnt_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear) begin
            clr_cnt_reg <= clr_cnt_reg + SW'(1);
        end
    end
    assign stat.clear_done = (clr_cnt_reg == SW'(sat_pkg::SLOTS - 1));

    // Capture the packet fields
    logic                         command_reg, version_reg;
    logic [7:0]                   slot_reg;
    logic [sat_pkg::PORT_W-1:0]   port_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            command_reg <= s_tdata[0];
            slot_reg    <= s_tdata[8:1];
            version_reg <= s_tdata[9];
            port_reg    <= s_tdata[14:10];
        end
    end

    // Slot memories: one row holds both versions, version 1 in the upper half
    logic [2*PN-1:0] seen_mem [sat_pkg::SLOTS];
    logic [2*CW-1:0] cnt_mem  [sat_pkg::SLOTS];
    logic [2*PN-1:0] seen_rd_reg;
    logic [2*CW-1:0] cnt_rd_reg;
    logic            mem_we;
    logic [SW-1:0]   mem_waddr;
    logic [2*PN-1:0] seen_wdata;
    logic [2*CW-1:0] cnt_wdata;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            seen_rd_reg <= seen_mem[s_tdata[SW:1]];
            cnt_rd_reg  <= cnt_mem[s_tdata[SW:1]];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            seen_mem[mem_waddr] <= seen_wdata;
            cnt_mem[mem_waddr]  <= cnt_wdata;
        end
    end

    // Select the entry of this version
    logic [PN-1:0] seen_here, seen_other, port_bit;
    logic [CW-1:0] cnt_here;
    assign seen_here  = version_reg ? seen_rd_reg[2*PN-1:PN] : seen_rd_reg[PN-1:0];
    assign seen_other = version_reg ? seen_rd_reg[PN-1:0] : seen_rd_reg[2*PN-1:PN];
    assign cnt_here   = version_reg ? cnt_rd_reg[2*CW-1:CW] : cnt_rd_reg[CW-1:0];
    assign port_bit   = PN'(1) << port_reg;

    // First remainder: advance the count modulo worker count
    logic [CW-1:0] rem1_reg;
    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            rem1_reg <= mod_small({1'b0, cnt_here} + 7'd1, w);
        end
    end

    // Second remainder and the decision
    logic [CW-1:0]        rem2;
    logic                 upd;
    logic [PN-1:0]        new_here, new_other;
    logic [CW-1:0]        new_cnt;
    sat_pkg::sat_action_t act;
    logic [sat_pkg::PORT_W-1:0] act_port;

    always_comb begin
        rem2      = mod_small({1'b0, rem1_reg}, u);
        upd       = 1'b0;
        new_here  = seen_here;
        new_other = seen_other;
        new_cnt   = cnt_here;
        act       = sat_pkg::ACT_DROP;
        act_port  = '0;
        if (command_reg == sat_pkg::CMD_DOWN) begin
            upd     = 1'b1;
            new_cnt = w;
            act     = sat_pkg::ACT_MCAST;
        end else if (job_finished_reg) begin
            act = sat_pkg::ACT_DROP;
        end else if ((seen_here & port_bit) != '0) begin
            // Repeat packet: shadow request
            if (cnt_here == w) begin
                act      = sat_pkg::ACT_REPLY;
                act_port = port_reg;
            end else if (!is_top_level_reg && cnt_here == '0) begin
                act = sat_pkg::ACT_UP;
            end else begin
                act = sat_pkg::ACT_ERROR;
            end
        end else begin
            upd       = 1'b1;
            new_here  = seen_here | port_bit;
            new_other = seen_other & ~port_bit;
            new_cnt   = rem2;
            if (rem2 == '0) begin
                if (is_top_level_reg) begin
                    new_cnt = w;
                    act     = sat_pkg::ACT_MCAST;
                end else begin
                    act = sat_pkg::ACT_UP;
                end
            end
        end
    end

    // Write back the row, or zero it during the clearing sweep
    always_comb begin
        mem_we    = cmd.clear | (cmd.commit & upd);
        mem_waddr = cmd.clear ? clr_cnt_reg : slot_reg[SW-1:0];
        if (cmd.clear) begin
            seen_wdata = '0;
            cnt_wdata  = '0;
        end else if (version_reg) begin
            seen_wdata = {new_here, new_other};
            cnt_wdata  = {new_cnt, cnt_rd_reg[CW-1:0]};
        end else begin
            seen_wdata = {new_other, new_here};
            cnt_wdata  = {cnt_rd_reg[2*CW-1:CW], new_cnt};
        end
    end

    // Result register
    logic        m_valid_reg;
    logic [23:0] m_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_data_reg <= {7'd0, version_reg, slot_reg, act_port, act};
        end
    end

    assign stat.out_busy = m_valid_reg & ~m_tready;
    assign m_tvalid      = m_valid_reg;
    assign m_tdata       = m_data_reg;

    // The multicast mask is stored but not used here; it only feeds an unused signal
    logic unused_mask;
    assign unused_mask = ^down_port_mask_reg ^ s_tdata[15];

endmodule
`default_nettype wire

FILE: src/slot_aggregation_tracker_unit.sv
// Flow: an accepted packet loads its fields and slot row, takes the first remainder in ST_CALC1,
// then the second remainder, write-back and result load in ST_CALC2, which stalls while the result
// register is full and not taken; one packet in flight, no new packet until back in ST_IDLE.
// Reset: synchronous, active low; clears config to reset values, then a sweep
// zeroes every slot row while s_tready stays low (config writes still taken).
`default_nettype none
module slot_aggregation_tracker_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // command[0], slot[8:1], version[9], from_port[14:10]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // action[2:0], out_port[7:3], slot_out[15:8],
                                        // version_out[16]
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    sat_pkg::sat_cmd_t  cmd;
    sat_pkg::sat_stat_t stat;

    sat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd),
        .ready    (s_tready)
    );

    sat_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule
`default_nettype wire

FILE: test/tb.sv
// Testbench for the slot aggregation tracker, checked against a local slot model.
`timescale 1ns / 100ps
module tb;

    typedef struct {
        logic       cmd;
        logic [7:0] slot;
        logic       version;
        logic [4:0] from_port;
    } packet_t;

    typedef struct {
        sat_pkg::sat_action_t action;
        logic [4:0]  port;
        logic [7:0]  slot;
        logic        version;
    } slot_result_t;

    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [15:0] s_tdata = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [23:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    // Register mirror, changed only while the block is idle
    logic [5:0]  cfg_workers = 6'd1;
    logic [5:0]  cfg_updates = 6'd1;
    logic        cfg_top = 1'b0;
    logic [31:0] cfg_mask = '0;
    logic        cfg_finished = 1'b0;

    // Slot rows, indexed by {slot, version}
    logic [31:0] port_seen [2*sat_pkg::SLOTS] = '{default: '0};
    logic [5:0]  agg_count [2*sat_pkg::SLOTS] = '{default: '0};

    packet_t      packet_q[$];
    slot_result_t due_results[$];
    int           sent_total = 0;
    int           results_done = 0;
    int           mismatch_count = 0;
    int           idle_pct = 14;
    int           hold_left = 0;
    bit           hold_done = 1'b0;

    slot_aggregation_tracker_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Apply one packet to the slot rows and return the action it causes
    function automatic slot_result_t track_packet(packet_t p);
        slot_result_t r;
        int           w;
        int           u;
        int           cnt;
        logic [8:0]   here;
        logic [8:0]   other;
        logic [31:0]  bit_mask;
        w = (cfg_workers == 0) ? 1 : int'(cfg_workers);
        u = (cfg_updates == 0) ? 1 : int'(cfg_updates);
        here = {p.slot, p.version};
        other = {p.slot, ~p.version};
        bit_mask = 32'd1 << p.from_port;
        r.action = sat_pkg::ACT_DROP;
        r.port = '0;
        r.slot = p.slot;
        r.version = p.version;
        if (p.cmd == sat_pkg::CMD_DOWN) begin
            agg_count[here] = 6'(w);
            r.action = sat_pkg::ACT_MCAST;
        end else if (cfg_finished) begin
            r.action = sat_pkg::ACT_DROP;
        end else if ((port_seen[here] & bit_mask) != 0) begin
            // Repeat from a counted port: shadow request
            cnt = int'(agg_count[here]);
            if (cnt == w) begin
                r.action = sat_pkg::ACT_REPLY;
                r.port = p.from_port;
            end else if (!cfg_top && cnt == 0) begin
                r.action = sat_pkg::ACT_UP;
            end else begin
                r.action = sat_pkg::ACT_ERROR;
            end
        end else begin
            port_seen[here] = port_seen[here] | bit_mask;
            port_seen[other] = port_seen[other] & ~bit_mask;
            cnt = ((int'(agg_count[here]) + 1) % w) % u;
            agg_count[here] = 6'(cnt);
            if (cnt == 0) begin
                if (cfg_top) begin
                    agg_count[here] = 6'(w);
                    r.action = sat_pkg::ACT_MCAST;
                end else begin
                    r.action = sat_pkg::ACT_UP;
                end
            end
        end
        return r;
    endfunction

    // Feed pending packets, holding each word until it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (packet_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                packet_t p;
                p = packet_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {1'b0, p.from_port, p.version, p.slot, p.cmd};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Check result words, then predict from accepted packets; drive m_tready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                slot_result_t got;
                slot_result_t want;
                got.action = sat_pkg::sat_action_t'(m_tdata[2:0]);
                got.port = m_tdata[7:3];
                got.slot = m_tdata[15:8];
                got.version = m_tdata[16];
                results_done++;
                if (due_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected word action %0d port %0d slot %0d ver %0d",
                                 $time, got.action, got.port, got.slot, got.version);
                end else begin
                    want = due_results.pop_front();
                    if (got.action !== want.action || got.port !== want.port ||
                        got.slot !== want.slot || got.version !== want.version) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: mismatch, expected action %0d port %0d slot %0d",
                                      " ver %0d, got action %0d port %0d slot %0d ver %0d"},
                                     $time, want.action, want.port, want.slot, want.version,
                                     got.action, got.port, got.slot, got.version);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                packet_t p;
                p.cmd = s_tdata[0];
                p.slot = s_tdata[8:1];
                p.version = s_tdata[9];
                p.from_port = s_tdata[14:10];
                due_results.push_back(track_packet(p));
            end
            // Hold off once for a long stretch so the input backs up
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && results_done >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    task automatic queue_packet(logic cmd, logic [7:0] slot, logic version, logic [4:0] port);
        packet_t p;
        p.cmd = cmd;
        p.slot = slot;
        p.version = version;
        p.from_port = port;
        packet_q.push_back(p);
        sent_total++;
    endtask

    task automatic set_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            sat_pkg::REG_WORKER_COUNT:   cfg_workers = val[5:0];
            sat_pkg::REG_UPDATE_COUNT:   cfg_updates = val[5:0];
            sat_pkg::REG_IS_TOP_LEVEL:   cfg_top = val[0];
            sat_pkg::REG_DOWN_PORT_MASK: cfg_mask = val;
            sat_pkg::REG_JOB_FINISHED:   cfg_finished = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] workers, logic [31:0] updates, logic top,
                             logic [31:0] mask, logic finished);
        set_reg(sat_pkg::REG_WORKER_COUNT, workers);
        set_reg(sat_pkg::REG_UPDATE_COUNT, updates);
        set_reg(sat_pkg::REG_IS_TOP_LEVEL, {31'd0, top});
        set_reg(sat_pkg::REG_DOWN_PORT_MASK, mask);
        set_reg(sat_pkg::REG_JOB_FINISHED, {31'd0, finished});
    endtask

    // Wait until every packet has produced its result word
    task automatic drain();
        while (results_done != sent_total)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly full aggregation rounds on a few hot slots, the rest noise
    task automatic queue_random(int n);
        int         added;
        int         k;
        int         start;
        logic [7:0] sl;
        logic       ver;
        added = 0;
        while (added < n) begin
            if ($urandom_range(0, 3) != 0) begin
                sl = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                ver = 1'($urandom);
                k = (cfg_workers == 0) ? 1 : int'(cfg_workers);
                if (k > sat_pkg::PORTS)
                    k = sat_pkg::PORTS;
                start = $urandom_range(0, 31);
                for (int i = 0; i < k && added < n; i++) begin
                    queue_packet(sat_pkg::CMD_UP, sl, ver, 5'(start + i));
                    added++;
                end
                // Resend one port as a shadow request
                if ($urandom_range(0, 1) != 0) begin
                    queue_packet(sat_pkg::CMD_UP, sl, ver,
                                 5'(start + $urandom_range(0, k - 1)));
                    added++;
                end
                if ($urandom_range(0, 3) == 0) begin
                    queue_packet(sat_pkg::CMD_DOWN, sl, ver, 5'($urandom));
                    added++;
                end
            end else begin
                queue_packet(($urandom_range(0, 5) == 0) ? sat_pkg::CMD_DOWN : sat_pkg::CMD_UP,
                             8'($urandom), 1'($urandom), 5'($urandom));
                added++;
            end
        end
    endtask

    // Stimulus phases
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Non-root switch: fill a slot, shadow repeats, downward reset, version swap
        configure(3, 3, 1'b0, 32'h0, 1'b0);
        queue_packet(sat_pkg::CMD_UP, 8'd0, 1'b0, 5'd0);
        queue_packet(sat_pkg::CMD_UP, 8'd0, 1'b0, 5'd1);
        queue_packet(sat_pkg::CMD_UP, 8'd0, 1'b0, 5'd2);
        queue_packet(sat_pkg::CMD_UP, 8'd0, 1'b0, 5'd0);
        queue_packet(sat_pkg::CMD_DOWN, 8'd0, 1'b0, 5'd0);
        queue_packet(sat_pkg::CMD_UP, 8'd0, 1'b0, 5'd1);
        queue_packet(sat_pkg::CMD_UP, 8'd255, 1'b1, 5'd31);
        queue_packet(sat_pkg::CMD_UP, 8'd255, 1'b1, 5'd31);
        queue_packet(sat_pkg::CMD_UP, 8'd0, 1'b1, 5'd0);
        queue_packet(sat_pkg::CMD_UP, 8'd0, 1'b0, 5'd0);
        drain();

        // Root switch: wrap multicasts, reply, error without shadow
        configure(2, 2, 1'b1, 32'hFFFF_FFFF, 1'b0);
        queue_packet(sat_pkg::CMD_UP, 8'd7, 1'b0, 5'd5);
        queue_packet(sat_pkg::CMD_UP, 8'd7, 1'b0, 5'd6);
        queue_packet(sat_pkg::CMD_UP, 8'd7, 1'b0, 5'd5);
        queue_packet(sat_pkg::CMD_UP, 8'd7, 1'b0, 5'd7);
        queue_packet(sat_pkg::CMD_UP, 8'd9, 1'b1, 5'd3);
        queue_packet(sat_pkg::CMD_UP, 8'd9, 1'b1, 5'd3);
        drain();

        // Finished job with zero counts and an empty mask
        configure(0, 0, 1'b0, 32'h0, 1'b1);
        queue_packet(sat_pkg::CMD_UP, 8'd1, 1'b0, 5'd1);
        queue_packet(sat_pkg::CMD_DOWN, 8'd1, 1'b1, 5'd0);
        drain();
        set_reg(sat_pkg::REG_JOB_FINISHED, 32'd0);
        queue_packet(sat_pkg::CMD_UP, 8'd200, 1'b1, 5'd17);
        queue_packet(sat_pkg::CMD_UP, 8'd200, 1'b1, 5'd17);
        drain();

        // Random phases over a spread of settings
        configure(4, 4, 1'b0, $urandom, 1'b0);
        queue_random(70);
        drain();

        idle_pct = 0;
        configure(4, 2, 1'b1, 32'hFFFF_FFFF, 1'b0);
        queue_random(70);
        drain();
        idle_pct = 14;

        configure(32, 32, 1'b0, $urandom, 1'b0);
        queue_random(80);
        drain();

        configure(1, 1, 1'b1, 32'h0, 1'b0);
        queue_random(40);
        drain();

        configure($urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom), $urandom, 1'b0);
        queue_random(80);
        drain();

        configure(5, 3, 1'b0, $urandom, 1'b1);
        queue_random(30);
        drain();

        configure(63, 63, 1'b1, $urandom, 1'b0);
        queue_random(30);
        drain();

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
src/sat_pkg.sv
src/sat_ctrl.sv
src/sat_datapath.sv
src/slot_aggregation_tracker_unit.sv
test/tb.sv
